FILE: rtl/insertion_sorter_defines.svh
// Assertion macros shared by the insertion sorter RTL.
`ifndef INSERTION_SORTER_DEFINES_SVH
`define INSERTION_SORTER_DEFINES_SVH

// Same-cycle implication, sampled on clk, muted during rst.
`define ISORT_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk, muted during rst.
`define ISORT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/isort_pkg.sv
// Shared types and constants for the insertion sorter.
package isort_pkg;

  localparam int DATA_W = 32;

  // What one cell shows to its neighbours.
  typedef struct packed {
    logic signed [DATA_W-1:0] data;
    logic                     occ;  // cell holds a value
    logic                     gt;   // held value is above the incoming one
  } link_t;

  // Broadcast control from the top level to every cell.
  typedef struct packed {
    logic                     ins;    // insert value this cycle
    logic                     shift;  // move contents one place towards cell 0
    logic signed [DATA_W-1:0] value;
  } ctl_t;

endpackage

FILE: rtl/isort_cell.sv
// One compare-and-shift cell of the sorting chain.
module isort_cell
  import isort_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  ctl_t  ctl,
  input  link_t left,
  input  link_t right,
  output link_t self
);

  logic signed [DATA_W-1:0] data;
  logic                     occ;
  logic                     gt;
  logic                     take;

  // Strict compare keeps equal values in arrival order.
  assign gt   = occ && (ctl.value < data);
  // Take a value if ours moves up, or if we are the first free slot.
  assign take = gt || (!occ && left.occ);

  always_ff @(posedge clk) begin
    if (rst) begin
      occ <= 1'b0;
    end else if (ctl.ins && take) begin
      occ <= 1'b1;
    end else if (ctl.shift) begin
      occ <= right.occ;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.ins && take) begin
      data <= left.gt ? left.data : ctl.value;
    end else if (ctl.shift) begin
      data <= right.data;
    end
  end

  assign self = '{data: data, occ: occ, gt: gt};

endmodule

FILE: rtl/insertion_sorter.sv
// Insertion sorter top level: chain of compare-and-shift cells plus drain control.
//
// Input stream (s_axis_*): one signed 32-bit value per request in tdata, tlast
// marks the final value of a set. While loading, tready is high and one value
// is taken every cycle; each value lands in its sorted place in the cell chain
// in the same cycle (all cells compare in parallel, larger values step up one
// cell). Values beyond MAX_ITEMS are dropped and the set is marked overflowed.
// Output stream (m_axis_*): after the request with tlast, the set is emitted
// in ascending order from cell 0, one value per cycle while the receiver is
// ready; tlast marks the final value, tuser carries the overflow flag on every
// value of the set. The first output is valid the cycle after the last input.
// The chain shifts towards cell 0 only on an accepted output, so a stalled
// receiver simply holds the current value. While draining, tready on the input
// is low. Equal values leave in arrival order.
// Reset (rst, synchronous) empties every cell, clears the overflow flag and
// returns the block to loading; no clearing pass is needed.
module insertion_sorter
  import isort_pkg::*;
#(
  parameter int MAX_ITEMS = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [DATA_W-1:0] s_axis_tdata,   // [31:0] value
  input  logic              s_axis_tlast,   // last_in
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [DATA_W-1:0] m_axis_tdata,   // [31:0] sorted_value
  output logic              m_axis_tlast,   // last_out
  output logic              m_axis_tuser    // [0] overflow
);

`include "insertion_sorter_defines.svh"

  typedef enum logic {S_LOAD, S_DRAIN} state_t;

  localparam link_t HEAD_LINK = '{data: '0, occ: 1'b1, gt: 1'b0};
  localparam link_t TAIL_LINK = '{data: '0, occ: 1'b0, gt: 1'b0};

  state_t                 state;
  logic                   dropped;
  ctl_t                   ctl;
  link_t                  lk [MAX_ITEMS];
  logic [MAX_ITEMS-1:0]   occ_vec;
  logic                   in_acc;
  logic                   out_acc;
  logic                   full;

  assign in_acc  = s_axis_tvalid && s_axis_tready;
  assign out_acc = m_axis_tvalid && m_axis_tready;
  assign full    = occ_vec[MAX_ITEMS-1];

  assign ctl = '{ins: in_acc && !full, shift: out_acc, value: $signed(s_axis_tdata)};

  // Cell chain: cell 0 sees a permanently occupied, never-shifting head;
  // the top cell sees an empty tail.
  for (genvar i = 0; i < MAX_ITEMS; i++) begin : g_cell
    link_t left_in;
    link_t right_in;
    if (i == 0) begin : g_head
      assign left_in = HEAD_LINK;
    end else begin : g_mid_l
      assign left_in = lk[i-1];
    end
    if (i == MAX_ITEMS-1) begin : g_tail
      assign right_in = TAIL_LINK;
    end else begin : g_mid_r
      assign right_in = lk[i+1];
    end
    isort_cell u_cell (
      .clk   (clk),
      .rst   (rst),
      .ctl   (ctl),
      .left  (left_in),
      .right (right_in),
      .self  (lk[i])
    );
    assign occ_vec[i] = lk[i].occ;
  end

  // Load / drain sequencing and the per-set overflow flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_LOAD;
      dropped <= 1'b0;
    end else begin
      case (state)
        S_LOAD: begin
          if (in_acc && full) begin
            dropped <= 1'b1;
          end
          if (in_acc && s_axis_tlast) begin
            state <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          if (out_acc && m_axis_tlast) begin
            state   <= S_LOAD;
            dropped <= 1'b0;
          end
        end
        default: begin
          state <= S_LOAD;
        end
      endcase
    end
  end

  assign s_axis_tready = (state == S_LOAD);
  assign m_axis_tvalid = (state == S_DRAIN) && occ_vec[0];
  assign m_axis_tdata  = lk[0].data;
  assign m_axis_tlast  = !occ_vec[1];
  assign m_axis_tuser  = dropped;

  // Occupied cells always form an unbroken run from cell 0.
  `ISORT_ASSERT_NOW(a_occ_contiguous, 1'b1,
    (occ_vec & (occ_vec + MAX_ITEMS'(1))) == '0, "cell occupancy not contiguous")
  // A drain always has at least one value to give.
  `ISORT_ASSERT_NOW(a_drain_nonempty, state == S_DRAIN, occ_vec[0],
    "draining with empty chain")
  // Final output leaves the chain empty.
  `ISORT_ASSERT_NEXT(a_empty_after_set, out_acc && m_axis_tlast, occ_vec == '0,
    "chain not empty after final output")
  // Overflow is raised only by a request arriving at a full chain.
  `ISORT_ASSERT_NOW(a_drop_when_full, $rose(dropped), $past(full) && $past(in_acc),
    "overflow set without a full chain")

endmodule

FILE: tb/tb_insertion_sorter.sv
// Self-checking testbench for the insertion sorter: directed sets, random sets, back-pressure.
`timescale 1ns / 100ps

module tb_insertion_sorter;
  import isort_pkg::*;

  localparam int MAX_ITEMS   = 16;
  localparam int STALL_LEN   = 150;  // receiver hold-off length in the pressure test
  localparam int MAX_REPORTS = 40;   // mismatch lines printed before going quiet

  // One expected output request of a sorted set.
  typedef struct packed {
    logic signed [DATA_W-1:0] sorted_value;
    logic                     last_out;
    logic                     overflow;
  } sorted_result_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [DATA_W-1:0] s_axis_tdata = '0;    // [31:0] value
  logic              s_axis_tlast = 1'b0;  // last_in
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  logic [DATA_W-1:0] m_axis_tdata;         // [31:0] sorted_value
  logic              m_axis_tlast;         // last_out
  logic              m_axis_tuser;         // [0] overflow

  // Predictor state: sorted contents of the current set, fill level, drop flag.
  logic signed [DATA_W-1:0] set_contents [MAX_ITEMS];
  int unsigned              set_fill = 0;
  bit                       set_dropped = 1'b0;
  sorted_result_t           pending_sorted[$];

  int mismatches     = 0;
  int send_idle_pct  = 0;
  int recv_idle_pct  = 0;
  int stall_trigger  = 0;  // bumped by the stimulus to ask for a long receiver hold-off
  int stall_seen     = 0;
  int stall_left     = 0;

  insertion_sorter #(.MAX_ITEMS(MAX_ITEMS)) dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #6 clk = ~clk;

  initial begin
    #2_000_000;
    $display("** insertion_sorter: FAILED **");
    $finish;
  end

  task automatic report_mismatch(input string what);
    if (mismatches < MAX_REPORTS) $display("[%0t] mismatch: %s", $realtime, what);
    mismatches++;
  endtask

  // Insert one accepted value; on the last of a set, queue the whole set in order.
  function automatic void insert_and_emit(input logic signed [DATA_W-1:0] v, input bit is_last);
    int             pos;
    sorted_result_t r;
    if (set_fill < MAX_ITEMS) begin
      pos = set_fill;
      // strict less-than: equal values stay behind earlier arrivals
      while (pos > 0 && v < set_contents[pos-1]) begin
        set_contents[pos] = set_contents[pos-1];
        pos--;
      end
      set_contents[pos] = v;
      set_fill++;
    end else begin
      set_dropped = 1'b1;
    end
    if (is_last) begin
      for (int k = 0; k < set_fill; k++) begin
        r.sorted_value = set_contents[k];
        r.last_out     = (k == set_fill - 1);
        r.overflow     = set_dropped;
        pending_sorted.push_back(r);
      end
      set_fill    = 0;
      set_dropped = 1'b0;
    end
  endfunction

  // Offer one value; returns on the edge at which the request is taken.
  task automatic send_request(input logic [DATA_W-1:0] v, input bit is_last);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= v;
    s_axis_tlast  <= is_last;
    do @(posedge clk); while (!(s_axis_tvalid && s_axis_tready));
    insert_and_emit(v, is_last);
  endtask

  // Mix of extremes, a narrow band around zero for ties, and full-range values.
  function automatic logic [DATA_W-1:0] pick_value();
    case ($urandom_range(7))
      0:       return 32'h8000_0000;
      1:       return 32'h7fff_ffff;
      2, 3:    return $urandom_range(15) - 8;
      default: return $urandom;
    endcase
  endfunction

  task automatic send_set(input int len);
    for (int i = 0; i < len; i++) send_request(pick_value(), i == len - 1);
  endtask

  // Sender goes quiet until every expected result has been taken.
  task automatic wait_for_drain();
    s_axis_tvalid <= 1'b0;
    while (pending_sorted.size() != 0) @(posedge clk);
  endtask

  // Receiver: checks every taken output request and drives tready.
  always @(posedge clk) begin
    sorted_result_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_sorted.size() == 0) begin
        report_mismatch($sformatf("unexpected output %h last=%b ovf=%b",
                                  m_axis_tdata, m_axis_tlast, m_axis_tuser));
      end else begin
        want = pending_sorted.pop_front();
        if (m_axis_tdata !== want.sorted_value)
          report_mismatch($sformatf("sorted_value %h, expected %h",
                                    m_axis_tdata, want.sorted_value));
        if (m_axis_tlast !== want.last_out)
          report_mismatch($sformatf("last_out %b, expected %b on value %h",
                                    m_axis_tlast, want.last_out, want.sorted_value));
        if (m_axis_tuser !== want.overflow)
          report_mismatch($sformatf("overflow %b, expected %b on value %h",
                                    m_axis_tuser, want.overflow, want.sorted_value));
      end
    end
    if (stall_trigger != stall_seen) begin
      stall_seen = stall_trigger;
      stall_left = STALL_LEN;
    end
    if (stall_left > 0) begin
      stall_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // A lone value at the bottom of the range: one result, flagged last.
  task automatic test_single_item();
    send_request(32'h8000_0000, 1'b1);
  endtask

  // Both ends of the range, zero, all ones, and a repeated value.
  task automatic test_extreme_values();
    send_request(32'h7fff_ffff, 1'b0);
    send_request(32'h0000_0000, 1'b0);
    send_request(32'hffff_ffff, 1'b0);
    send_request(32'h8000_0000, 1'b0);
    send_request(32'h0000_0001, 1'b0);
    send_request(32'hffff_ffff, 1'b1);
  endtask

  // Two more than the store holds; the last request is itself dropped but still drains.
  task automatic test_overflow_drop();
    for (int i = 0; i < MAX_ITEMS + 2; i++)
      send_request(pick_value(), i == MAX_ITEMS + 1);
  endtask

  // Receiver holds off while sets keep coming, so the block stalls its input.
  task automatic test_back_pressure();
    send_idle_pct = 0;
    stall_trigger <= stall_trigger + 1;
    send_set(MAX_ITEMS);
    send_set(5);
    send_set(MAX_ITEMS + 3);
    wait_for_drain();
  endtask

  task automatic test_random_sets(input int n_items);
    int sent;
    int len;
    sent = 0;
    while (sent < n_items) begin
      case ($urandom_range(9))
        0:       len = $urandom_range(MAX_ITEMS + 6, MAX_ITEMS + 1);
        1:       len = MAX_ITEMS;
        default: len = $urandom_range(MAX_ITEMS, 1);
      endcase
      send_set(len);
      sent += len;
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    send_idle_pct = 22;
    recv_idle_pct <= 81;
    test_single_item();
    test_extreme_values();
    test_overflow_drop();
    test_random_sets(60);
    wait_for_drain();

    send_idle_pct = 81;
    recv_idle_pct <= 22;
    test_random_sets(60);
    wait_for_drain();

    recv_idle_pct <= 0;
    test_back_pressure();
    send_idle_pct = 0;
    test_random_sets(60);

    wait_for_drain();
    repeat (20) @(posedge clk);
    if (mismatches == 0 && pending_sorted.size() == 0) begin
      $display("** insertion_sorter: PASSED **");
    end else begin
      $display("** insertion_sorter: FAILED **");
    end
    $finish;
  end

endmodule

FILE: sim.f
+incdir+rtl
rtl/isort_pkg.sv
rtl/isort_cell.sv
rtl/insertion_sorter.sv
tb/tb_insertion_sorter.sv
